// ===== sv/swmm_pkg.sv =====
// Shared types and constants for the sliding window min/max channel.
`timescale 1ns / 1ps

package swmm_pkg;

   // Width of the window length field on the configuration port.
   localparam int WINDOW_LEN_W = 9;

   // Window length after reset, before it is limited to the ring depth.
   localparam int WINDOW_LEN_RESET = 20;

   // Per-item control handed from the sequencer to each extreme tracker.
   typedef struct packed {
      logic restart;   // configuration write: return to the reset extreme
      logic accept;    // a new word is taken this cycle
      logic full;      // the window already held window_length samples
      logic scan_hit;  // read data from the ring is valid this cycle
   } swmm_ext_ctrl_type;

endpackage

// ===== sv/sliding_window_min_max_channel_top.sv =====
// Top level of the sliding window min/max price channel.
// A word that does not retire a stored extreme needs no rescan; one that retires an extreme,
// with window_length above 1, first rescans the older ring samples, one per cycle from
// the single read port of each ring store. Only a word that leaves window_length samples
// in the window gives a response. Words are taken only in the idle state.
// Reset clears control state, not ring contents; window_length resets to min(20, MAX_PERIOD).
`timescale 1ns / 1ps

module sliding_window_min_max_channel_top #(
   parameter int MAX_PERIOD   = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [SAMPLE_WIDTH-1:0]           req_high_price,
   input  logic [SAMPLE_WIDTH-1:0]           req_low_price,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]           rsp_channel_low,
   output logic [SAMPLE_WIDTH-1:0]           rsp_channel_high,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [swmm_pkg::WINDOW_LEN_W-1:0] csr_window_length
);

   import swmm_pkg::*;

   localparam int ADDR_W  = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
   localparam int LEN_W   = $clog2(MAX_PERIOD + 1);
   localparam int CW      = (LEN_W > WINDOW_LEN_W) ? LEN_W : WINDOW_LEN_W;
   localparam int DEF_LEN = (MAX_PERIOD < WINDOW_LEN_RESET) ? MAX_PERIOD : WINDOW_LEN_RESET;
   localparam logic [CW-1:0]    MAX_LEN   = CW'(MAX_PERIOD);
   localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'(DEF_LEN);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        seen_ff, seen_in;
   logic [ADDR_W-1:0]       wr_slot_ff, wr_slot_in;
   logic [ADDR_W-1:0]       rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0]       rd_left_ff, rd_left_in;
   logic                    scan_vld_ff, scan_vld_in;
   logic [ADDR_W-1:0]       scan_slot_ff, scan_slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_low_ff, rsp_low_in;
   logic [SAMPLE_WIDTH-1:0] rsp_high_ff, rsp_high_in;

   logic                    req_take;
   logic                    csr_take;
   logic                    full;
   logic [LEN_W-1:0]        len_m1;
   logic [ADDR_W-1:0]       prev_slot;
   logic [LEN_W-1:0]        seen_next;
   logic                    issue;
   logic                    out_free;
   logic [CW-1:0]           csr_ext;
   logic [LEN_W-1:0]        csr_len;
   logic [ADDR_W-1:0]       mem_addr;
   logic [SAMPLE_WIDTH-1:0] high_rdata, low_rdata;
   logic                    high_expire, low_expire;
   logic [SAMPLE_WIDTH-1:0] high_ext, low_ext;
   swmm_ext_ctrl_type       ext_ctrl;

   // Configuration is taken only between words; it wins over a waiting word.
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_take  = csr_valid && csr_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      csr_ext = CW'(csr_window_length);
      if (csr_ext == '0) begin
         csr_len = LEN_W'(1);
      end else if (csr_ext > MAX_LEN) begin
         csr_len = LEN_W'(MAX_LEN);
      end else begin
         csr_len = LEN_W'(csr_ext);
      end
   end

   assign full      = (seen_ff >= len_ff);
   assign len_m1    = len_ff - LEN_W'(1);
   assign seen_next = full ? seen_ff : seen_ff + LEN_W'(1);
   assign prev_slot = (wr_slot_ff == '0) ? ADDR_W'(len_m1) : wr_slot_ff - ADDR_W'(1);
   assign issue     = (state_ff == ST_SCAN) && (rd_left_ff != '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mem_addr  = req_take ? wr_slot_ff : rd_addr_ff;

   assign ext_ctrl.restart  = csr_take;
   assign ext_ctrl.accept   = req_take;
   assign ext_ctrl.full     = full;
   assign ext_ctrl.scan_hit = scan_vld_ff;

   swmm_ring_mem #(
      .DEPTH  (MAX_PERIOD),
      .ADDR_W (ADDR_W),
      .DATA_W (SAMPLE_WIDTH)
   ) u_high_mem (
      .clock (clock),
      .we    (req_take),
      .addr  (mem_addr),
      .wdata (req_high_price),
      .rdata (high_rdata)
   );

   swmm_ring_mem #(
      .DEPTH  (MAX_PERIOD),
      .ADDR_W (ADDR_W),
      .DATA_W (SAMPLE_WIDTH)
   ) u_low_mem (
      .clock (clock),
      .we    (req_take),
      .addr  (mem_addr),
      .wdata (req_low_price),
      .rdata (low_rdata)
   );

   swmm_extreme #(
      .IS_MAX       (1'b1),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ADDR_W       (ADDR_W)
   ) u_high_ext (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ext_ctrl),
      .new_sample  (req_high_price),
      .wr_slot     (wr_slot_ff),
      .scan_sample (high_rdata),
      .scan_slot   (scan_slot_ff),
      .expire      (high_expire),
      .extreme     (high_ext)
   );

   swmm_extreme #(
      .IS_MAX       (1'b0),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ADDR_W       (ADDR_W)
   ) u_low_ext (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ext_ctrl),
      .new_sample  (req_low_price),
      .wr_slot     (wr_slot_ff),
      .scan_sample (low_rdata),
      .scan_slot   (scan_slot_ff),
      .expire      (low_expire),
      .extreme     (low_ext)
   );

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      seen_in      = seen_ff;
      wr_slot_in   = wr_slot_ff;
      rd_addr_in   = rd_addr_ff;
      rd_left_in   = rd_left_ff;
      scan_vld_in  = 1'b0;
      scan_slot_in = scan_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_take) begin
               len_in     = csr_len;
               seen_in    = '0;
               wr_slot_in = '0;
            end else if (req_take) begin
               seen_in    = seen_next;
               wr_slot_in = (LEN_W'(wr_slot_ff) == len_m1) ? '0 : wr_slot_ff + ADDR_W'(1);
               // The older samples are read newest first, starting one slot back.
               rd_addr_in = prev_slot;
               rd_left_in = ADDR_W'(len_m1);
               if ((high_expire || low_expire) && (len_ff != LEN_W'(1))) begin
                  state_in = ST_SCAN;
               end else if (seen_next >= len_ff) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_vld_in  = 1'b1;
               scan_slot_in = rd_addr_ff;
               rd_addr_in   = (rd_addr_ff == '0) ? ADDR_W'(len_m1) : rd_addr_ff - ADDR_W'(1);
               rd_left_in   = rd_left_ff - ADDR_W'(1);
            end else if (scan_vld_ff) begin
               // The last sample is folded in at this edge.
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_low_in   = low_ext;
               rsp_high_in  = high_ext;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= RESET_LEN;
         seen_ff      <= '0;
         wr_slot_ff   <= '0;
         rd_left_ff   <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         wr_slot_ff   <= wr_slot_in;
         rd_left_ff   <= rd_left_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      scan_slot_ff <= scan_slot_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel_low  = rsp_low_ff;
   assign rsp_channel_high = rsp_high_ff;

   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(wr_slot_ff) < len_ff)
      else $error("write slot outside the window");

   a_seen_saturates: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= len_ff)
      else $error("sample count above the window length");

   a_scan_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_vld_ff |-> (state_ff == ST_SCAN))
      else $error("ring read data outside a rescan");

   a_scan_needs_full: assert property (@(posedge clock) disable iff (reset)
      (req_take && (state_in == ST_SCAN)) |-> full)
      else $error("rescan started before the window filled");

endmodule

// ===== sv/swmm_ring_mem.sv =====
// Single-port ring store with a registered read, one sample per entry.
`timescale 1ns / 1ps

module swmm_ring_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/swmm_extreme.sv =====
// Tracks one running extreme of the window and the ring slot that holds it.
`timescale 1ns / 1ps

module swmm_extreme #(
   parameter bit IS_MAX       = 1'b1,
   parameter int SAMPLE_WIDTH = 32,
   parameter int ADDR_W       = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swmm_pkg::swmm_ext_ctrl_type    ctrl,
   input  logic [SAMPLE_WIDTH-1:0]        new_sample,
   input  logic [ADDR_W-1:0]              wr_slot,
   input  logic [SAMPLE_WIDTH-1:0]        scan_sample,
   input  logic [ADDR_W-1:0]              scan_slot,
   output logic                           expire,
   output logic [SAMPLE_WIDTH-1:0]        extreme
);

   import swmm_pkg::*;

   // Most negative value for a maximum, most positive for a minimum.
   localparam logic [SAMPLE_WIDTH-1:0] EXT_INIT = IS_MAX ?
      {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

   logic [SAMPLE_WIDTH-1:0] best_ff, best_in;
   logic [ADDR_W-1:0]       slot_ff, slot_in;
   logic                    rescan_ff, rescan_in;
   logic                    new_wins;
   logic                    scan_wins;

   assign expire = ctrl.full && (slot_ff == wr_slot);

   // A new sample wins ties; during a rescan an older one must be strictly better.
   assign new_wins  = IS_MAX ? ($signed(new_sample) >= $signed(best_ff))
                             : ($signed(new_sample) <= $signed(best_ff));
   assign scan_wins = IS_MAX ? ($signed(scan_sample) > $signed(best_ff))
                             : ($signed(scan_sample) < $signed(best_ff));

   always_comb begin
      best_in   = best_ff;
      slot_in   = slot_ff;
      rescan_in = rescan_ff;
      if (ctrl.restart) begin
         best_in   = EXT_INIT;
         slot_in   = '0;
         rescan_in = 1'b0;
      end else if (ctrl.accept) begin
         rescan_in = expire;
         if (expire || new_wins) begin
            best_in = new_sample;
            slot_in = wr_slot;
         end
      end else if (ctrl.scan_hit && rescan_ff && scan_wins) begin
         best_in = scan_sample;
         slot_in = scan_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff   <= EXT_INIT;
         slot_ff   <= '0;
         rescan_ff <= 1'b0;
      end else begin
         best_ff   <= best_in;
         slot_ff   <= slot_in;
         rescan_ff <= rescan_in;
      end
   end

   assign extreme = best_ff;

endmodule
